// ----- rtl/multi_mode_byte_crc_defines.svh -----
// Assertion macros shared by the multi-mode byte CRC RTL.
`ifndef MULTI_MODE_BYTE_CRC_DEFINES_SVH
`define MULTI_MODE_BYTE_CRC_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define MMBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define MMBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mmbc_pkg.sv -----
// Package: mode codes, transaction types and CRC fold/finish functions.
`timescale 1ns / 1ps

package mmbc_pkg;

    localparam logic [2:0] MODE_CRC8         = 3'd0;
    localparam logic [2:0] MODE_CRC16_KERMIT = 3'd1;
    localparam logic [2:0] MODE_CRC16_XMODEM = 3'd2;
    localparam logic [2:0] MODE_CRC32        = 3'd3;
    localparam logic [2:0] MODE_CRC32_MPEG2  = 3'd4;

    localparam logic [31:0] POLY_CRC8  = 32'h0000_0007;
    localparam logic [31:0] POLY_CRC16 = 32'h0000_1021;
    localparam logic [31:0] POLY_CRC32 = 32'h04C1_1DB7;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_8     = 32'h0000_00FF;
    localparam logic [31:0] MASK_16    = 32'h0000_FFFF;
    localparam logic [31:0] TOP_8      = 32'h0000_0080;
    localparam logic [31:0] TOP_16     = 32'h0000_8000;
    localparam logic [31:0] TOP_32     = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] crc;
    } t_result;

    function automatic logic [31:0] mode_init(input logic [2:0] mode);
        logic [31:0] v;
        case (mode)
            MODE_CRC32, MODE_CRC32_MPEG2: v = ALL_ONES;
            default:                      v = '0;
        endcase
        return v;
    endfunction

    // Folds one byte into the MSB-first, right-aligned CRC register.
    function automatic logic [31:0] crc_fold(input logic [2:0]  mode,
                                             input logic [31:0] crc,
                                             input logic [7:0]  data);
        logic [31:0] mask;
        logic [31:0] poly;
        logic [31:0] top;
        logic [31:0] c;
        logic [7:0]  rb;
        int          i;
        for (i = 0; i < 8; i++) begin
            rb[7 - i] = data[i];
        end
        mask = ALL_ONES;
        poly = POLY_CRC32;
        top  = TOP_32;
        c    = '0;
        case (mode)
            MODE_CRC8: begin
                mask = MASK_8;
                poly = POLY_CRC8;
                top  = TOP_8;
                c    = (crc & MASK_8) ^ {24'h0, data};
            end
            MODE_CRC16_KERMIT: begin
                mask = MASK_16;
                poly = POLY_CRC16;
                top  = TOP_16;
                c    = (crc & MASK_16) ^ {16'h0, rb, 8'h0};
            end
            MODE_CRC16_XMODEM: begin
                mask = MASK_16;
                poly = POLY_CRC16;
                top  = TOP_16;
                c    = (crc & MASK_16) ^ {16'h0, data, 8'h0};
            end
            MODE_CRC32: begin
                c = crc ^ {rb, 24'h0};
            end
            MODE_CRC32_MPEG2: begin
                c = crc ^ {data, 24'h0};
            end
            default: begin
                mask = '0;
            end
        endcase
        for (i = 0; i < 8; i++) begin
            if ((c & top) != '0) begin
                c = ((c << 1) ^ poly) & mask;
            end else begin
                c = (c << 1) & mask;
            end
        end
        return c;
    endfunction

    // Output reflection and final inversion per mode.
    function automatic logic [31:0] crc_finish(input logic [2:0]  mode,
                                               input logic [31:0] crc);
        logic [31:0] r;
        int          i;
        r = '0;
        case (mode)
            MODE_CRC8:         r = crc & MASK_8;
            MODE_CRC16_XMODEM,
            MODE_CRC32_MPEG2:  r = crc;
            MODE_CRC16_KERMIT: begin
                for (i = 0; i < 16; i++) begin
                    r[15 - i] = crc[i];
                end
            end
            MODE_CRC32: begin
                for (i = 0; i < 32; i++) begin
                    r[31 - i] = crc[i];
                end
                r = r ^ ALL_ONES;
            end
            default:           r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/mmbc_in_stage.sv -----
// Input register: holds one byte transaction until the engine takes it.
`timescale 1ns / 1ps

module mmbc_in_stage
    import mmbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_out_ready,
    output logic       o_go,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    // A last byte needs room in the result register; other bytes always move.
    assign o_go       = r_valid && (!r_item.last_byte || i_out_ready);
    assign o_in_stall = r_valid && !o_go;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte <= i_data_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

endmodule

// ----- rtl/mmbc_engine.sv -----
// CRC engine: mode register, running CRC register and per-byte fold.
`timescale 1ns / 1ps
`include "multi_mode_byte_crc_defines.svh"

module mmbc_engine
    import mmbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_mode,
    input  logic       i_go,
    input  t_item      i_item,
    output t_result    o_res
);

    logic [2:0]  r_mode;
    logic [31:0] r_crc;
    logic [2:0]  n_mode;
    logic [31:0] n_crc;
    logic [31:0] folded;

    assign folded = crc_fold(r_mode, r_crc, i_item.data_byte);

    always_comb begin
        n_mode = r_mode;
        n_crc  = r_crc;
        if (i_cfg_we) begin
            n_mode = i_cfg_mode;
            n_crc  = mode_init(i_cfg_mode);
        end else if (i_go) begin
            n_crc = i_item.last_byte ? mode_init(r_mode) : folded;
        end
    end

    assign o_res.valid = i_go && i_item.last_byte;
    assign o_res.crc   = crc_finish(r_mode, folded);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CRC8;
            r_crc  <= '0;
        end else begin
            r_mode <= n_mode;
            r_crc  <= n_crc;
        end
    end

    `MMBC_ASSERT_NOW(a_unused_mode_zero, r_mode > MODE_CRC32_MPEG2, r_crc == '0, "crc not zero in unused mode")
    `MMBC_ASSERT_NOW(a_crc8_narrow, r_mode == MODE_CRC8, r_crc[31:8] == '0, "crc8 upper bits set")
    `MMBC_ASSERT_NOW(a_crc16_narrow, r_mode == MODE_CRC16_KERMIT || r_mode == MODE_CRC16_XMODEM, r_crc[31:16] == '0, "crc16 upper bits set")

endmodule

// ----- rtl/mmbc_out_stage.sv -----
// Result register: holds a finished CRC until the receiver takes it.
`timescale 1ns / 1ps

module mmbc_out_stage
    import mmbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_res,
    output logic        o_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_crc_value
);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_crc;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_crc_value = r_crc;

    always_comb begin
        n_valid = r_valid;
        if (i_res.valid) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_crc <= i_res.crc;
        end
    end

endmodule

// ----- rtl/multi_mode_byte_crc.sv -----
// Top level of the multi-mode byte CRC engine.
//
//   channel  handshake                 payload
//   in       i_in_valid / o_in_stall    i_data_byte, i_last_byte
//   out      o_out_valid / i_out_stall  o_crc_value
//   cfg      i_cfg_valid / o_cfg_ready  i_cfg_data (crc_mode)
//
// One byte per cycle while o_in_stall is low; a last byte passes the input register, then the result register.
// Input register, then the 8-step fold into the CRC register and result register.
// Synchronous active-low reset: mode 0, CRC register 0, both stages empty.
// A held result keeps a last byte in the input register and the input stalls behind it.
`timescale 1ns / 1ps
`include "multi_mode_byte_crc_defines.svh"

module multi_mode_byte_crc
    import mmbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_crc_value
);

    logic    out_ready;
    logic    go;
    logic    cfg_we;
    t_item   item;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    mmbc_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_out_ready (out_ready),
        .o_go        (go),
        .o_item      (item)
    );

    mmbc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_mode (i_cfg_data),
        .i_go       (go),
        .i_item     (item),
        .o_res      (res)
    );

    mmbc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

    `MMBC_ASSERT_NOW(a_result_has_room, res.valid, out_ready, "result produced while result register busy")
    `MMBC_ASSERT_NEXT(a_result_lands, res.valid, o_out_valid && o_crc_value == $past(res.crc), "finished crc not in result register")

endmodule

// ----- test/multi_mode_byte_crc_tb.sv -----
// Testbench for multi_mode_byte_crc: checks every finished CRC against a predictor.
`timescale 1ns / 1ps

module multi_mode_byte_crc_tb;
    import mmbc_pkg::*;

    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 150;
    localparam int IDLE_LIMIT     = 4000;
    localparam int MAX_REPORTS    = 40;
    localparam int NUM_PHASES     = 15;
    localparam int PRESSURE_PHASE = 2;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_crc_value;

    multi_mode_byte_crc dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

    t_item       byte_q[$];
    logic [31:0] crc_expect_q[$];
    logic [2:0]  model_mode = MODE_CRC8;
    logic [31:0] crc_state  = '0;
    int          mismatches = 0;
    int          hold_requests = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [31:0] seed_for(input logic [2:0] mode);
        return (mode == MODE_CRC32 || mode == MODE_CRC32_MPEG2) ? ALL_ONES : 32'h0;
    endfunction

    function automatic logic [31:0] reflect32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    function automatic void fold_byte(input logic [7:0] data, input logic last,
                                      output logic emit, output logic [31:0] crc_out);
        int          width;
        logic [31:0] poly;
        logic [31:0] mask;
        logic [31:0] b32;
        logic [31:0] c;
        logic        refl;
        emit    = last;
        crc_out = '0;
        width   = 32;
        poly    = POLY_CRC32;
        refl    = 1'b0;
        case (model_mode)
            MODE_CRC8: begin
                width = 8;
                poly  = POLY_CRC8;
            end
            MODE_CRC16_KERMIT: begin
                width = 16;
                poly  = POLY_CRC16;
                refl  = 1'b1;
            end
            MODE_CRC16_XMODEM: begin
                width = 16;
                poly  = POLY_CRC16;
            end
            MODE_CRC32: begin
                refl = 1'b1;
            end
            MODE_CRC32_MPEG2: begin
                refl = 1'b0;
            end
            default: begin
                crc_state = '0;
                return;
            end
        endcase
        mask = (width == 32) ? ALL_ONES : ((32'd1 << width) - 32'd1);
        b32  = refl ? (reflect32({24'h0, data}) >> 24) : {24'h0, data};
        c    = (crc_state & mask) ^ (b32 << (width - 8));
        for (int k = 0; k < 8; k++) begin
            if (c[width - 1]) begin
                c = ((c << 1) ^ poly) & mask;
            end else begin
                c = (c << 1) & mask;
            end
        end
        crc_state = c;
        if (last) begin
            crc_out = refl ? (reflect32(c) >> (32 - width)) : c;
            if (model_mode == MODE_CRC32) begin
                crc_out = ~crc_out;
            end
            crc_out   = crc_out & mask;
            crc_state = seed_for(model_mode);
        end
    endfunction

    // sender: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin : drive_bytes
        t_item       it;
        logic        emit;
        logic [31:0] crc;
        int          burst_left;
        int          gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                fold_byte(i_data_byte, i_last_byte, emit, crc);
                if (emit) begin
                    crc_expect_q.push_back(crc);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    it = byte_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= it.data_byte;
                    i_last_byte <= it.last_byte;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall styles plus requested long holds
    always @(posedge i_clk) begin : drive_stall
        int         hold_left;
        int         holds_done;
        int         style;
        int         style_left;
        logic [3:0] tick;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left  = 0;
            holds_done = 0;
            style      = 0;
            style_left = 0;
            tick       = '0;
        end else begin
            tick = tick + 4'd1;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 200);
                end else begin
                    style_left--;
                end
                case (style)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= (tick[2:0] == 3'b011) || (tick[3:1] == 3'b110);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        logic [31:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (crc_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected transaction, crc_value expected none actual %h",
                             $time, o_crc_value);
                end
            end else begin
                want = crc_expect_q.pop_front();
                if (o_crc_value !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: crc_value expected %h actual %h",
                                 $time, want, o_crc_value);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // sampled mid-cycle so the sender's and checker's updates have settled
    task automatic drain_and_settle();
        while (byte_q.size() != 0 || i_in_valid || crc_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [2:0] mode);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        model_mode = mode;
        crc_state  = seed_for(mode);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_item it;
        it.data_byte = data;
        it.last_byte = last;
        byte_q.push_back(it);
    endtask

    task automatic queue_messages(input int n_bytes, input int max_len);
        int left;
        int len;
        left = n_bytes;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, max_len);
            if (len > left) begin
                len = left;
            end
            for (int k = 0; k < len; k++) begin
                push_byte(pick_byte(), k == len - 1);
            end
            left -= len;
        end
        // unfinished message, dropped by the next mode write
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 5)) push_byte(pick_byte(), 1'b0);
        end
    endtask

    initial begin : stimulus
        logic [2:0] all_modes[8];
        logic [2:0] phase_modes[NUM_PHASES];
        all_modes = '{MODE_CRC8, MODE_CRC16_KERMIT, MODE_CRC16_XMODEM, MODE_CRC32,
                      MODE_CRC32_MPEG2, MODE_UNUSED_5, MODE_UNUSED_6, MODE_UNUSED_7};
        phase_modes = '{MODE_CRC32, MODE_CRC8, MODE_CRC16_KERMIT, MODE_UNUSED_7,
                        MODE_CRC16_XMODEM, MODE_CRC32_MPEG2, MODE_CRC8, MODE_UNUSED_5,
                        MODE_CRC32, MODE_CRC16_KERMIT, MODE_CRC32_MPEG2, MODE_UNUSED_6,
                        MODE_CRC16_XMODEM, MODE_CRC32, MODE_CRC8};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode, extreme bytes, a trailing unfinished message
        for (int m = 0; m < 8; m++) begin
            if (m != 0) begin
                drain_and_settle();
                write_mode(all_modes[m]);
            end
            @(negedge i_clk);
            push_byte(8'hFF, 1'b1);
            push_byte(8'h00, 1'b1);
            push_byte(8'h80, 1'b0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_settle();
            write_mode(phase_modes[p]);
            if (p == PRESSURE_PHASE) begin
                hold_requests <= hold_requests + 1;
            end
            @(negedge i_clk);
            if (phase_modes[p] > MODE_CRC32_MPEG2) begin
                queue_messages(15, 4);
            end else if (p == PRESSURE_PHASE) begin
                queue_messages(105, 2);
            end else begin
                queue_messages(105, 12);
            end
        end

        drain_and_settle();
        if (mismatches == 0 && crc_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
